/* src/aptc_pkg.sv */
// Shared constants and types for the asymmetric PI threshold controller.
package aptc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int ACC_WIDTH = 40;

    localparam int FRAC_W = FRAC_BITS + 1;
    localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1 << FRAC_BITS);

    localparam int GAIN_W = 24;
    localparam int ERR_W = FRAC_W + 1;
    localparam int NUM_W = 2 * FRAC_BITS + 1;
    localparam int DIV_STEPS = FRAC_W;
    localparam int CNT_W = $clog2(DIV_STEPS);

    localparam int ACC_EXT_W = ACC_WIDTH + 1;
    localparam int ACC_LO_W = ACC_WIDTH / 2;
    localparam int ACC_HI_W = ACC_WIDTH - ACC_LO_W;
    localparam int PP_LO_W = ACC_LO_W + 1 + GAIN_W;
    localparam int PP_HI_W = ACC_HI_W + GAIN_W;
    localparam int IPROD_W = ACC_WIDTH + GAIN_W;
    localparam int PPROD_W = ERR_W + GAIN_W;
    localparam int ITERM_W = IPROD_W - FRAC_BITS;
    localparam int PTERM_W = PPROD_W - FRAC_BITS;
    localparam int SUM_W = ITERM_W + 1;
    localparam int RES_W = SUM_W + 1;

    localparam int DATA_W = 32;
    localparam int PADDR_W = 4;
    localparam int REG_IDX_W = 2;
    localparam int IN_TDATA_W = 24;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_TUSER_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_HOT_FRACTION = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_PROP_GAIN = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_INTEG_GAIN = 2'd2;

    typedef struct packed {
        logic [FRAC_W-1:0]        hot_fraction;
        logic signed [GAIN_W-1:0] prop_gain;
        logic signed [GAIN_W-1:0] integ_gain;
    } t_cfg;

    typedef struct packed {
        logic capture;
        logic prep;
        logic div_step;
        logic integ;
        logic mul0;
        logic mul1;
        logic acc;
        logic sum;
        logic fin;
    } t_dp_cmd;

    typedef struct packed {
        logic corner;
    } t_dp_status;

endpackage

/* src/aptc_regs.sv */
// APB configuration registers: target hot share and the two loop gains.
module aptc_regs import aptc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output t_cfg               o_cfg
);

    t_cfg r_cfg;
    logic w_wr;
    logic [REG_IDX_W-1:0] w_idx;

    assign w_wr  = psel & penable & pwrite;
    assign w_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hot_fraction <= FRAC_W'(1 << (FRAC_BITS - 1));
            r_cfg.prop_gain    <= '0;
            r_cfg.integ_gain   <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_HOT_FRACTION: r_cfg.hot_fraction <= pwdata[FRAC_W-1:0];
                REG_PROP_GAIN:    r_cfg.prop_gain <= $signed(pwdata[GAIN_W-1:0]);
                REG_INTEG_GAIN:   r_cfg.integ_gain <= $signed(pwdata[GAIN_W-1:0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_HOT_FRACTION: prdata = DATA_W'(r_cfg.hot_fraction);
            REG_PROP_GAIN:    prdata = DATA_W'(unsigned'(r_cfg.prop_gain));
            REG_INTEG_GAIN:   prdata = DATA_W'(unsigned'(r_cfg.integ_gain));
            default:          prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

/* src/aptc_ctrl.sv */
// Sequencer that steps one word through divide, integrate, multiply and clamp.
module aptc_ctrl import aptc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_PREP  = 9'b000000010,
        S_DIV   = 9'b000000100,
        S_INTEG = 9'b000001000,
        S_MUL0  = 9'b000010000,
        S_MUL1  = 9'b000100000,
        S_ACC   = 9'b001000000,
        S_SUM   = 9'b010000000,
        S_FIN   = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic r_out_valid, n_out_valid;
    logic w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_cnt = '0;
                n_state = i_status.corner ? S_FIN : S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_INTEG;
                end
            end
            S_INTEG: begin
                o_cmd.integ = 1'b1;
                n_state = S_MUL0;
            end
            S_MUL0: begin
                o_cmd.mul0 = 1'b1;
                n_state = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (w_out_free) begin
                    o_cmd.fin = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

/* src/aptc_dp.sv */
// Datapath: error divider, saturating integrator, gain products and output clamp.
module aptc_dp import aptc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  t_dp_cmd           i_cmd,
    input  logic [FRAC_W-1:0] i_measured_fraction,
    output t_dp_status        o_status,
    output logic [FRAC_W-1:0] o_threshold,
    output logic              o_clamped,
    output logic              o_bypass
);

    localparam logic signed [RES_W-1:0] RES_ONE = RES_W'(FRAC_ONE);
    localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

    logic [FRAC_W-1:0] r_f_raw;
    logic [FRAC_W-1:0] r_f, r_b;
    logic              r_neg, r_bypass;
    logic [FRAC_W-1:0] r_rem, r_dq, r_div;
    logic signed [ERR_W-1:0]     r_err;
    logic signed [ACC_WIDTH-1:0] r_integ;
    logic signed [PP_LO_W-1:0]   r_pp_lo;
    logic signed [PP_HI_W-1:0]   r_pp_hi;
    logic signed [PPROD_W-1:0]   r_pprod;
    logic signed [IPROD_W-1:0]   r_iprod;
    logic signed [SUM_W-1:0]     r_sum;
    logic [FRAC_W-1:0] r_thr;
    logic              r_clamped, r_bypass_out;

    logic [FRAC_W-1:0] w_f, w_b, w_a, w_op_x, w_op_y, w_divisor;
    logic              w_neg;
    logic [NUM_W-1:0]  w_num;
    logic [FRAC_W:0]   w_trial, w_diff;
    logic              w_ge;
    logic signed [ERR_W-1:0]     w_err;
    logic signed [ACC_EXT_W-1:0] w_isum;
    logic signed [ACC_WIDTH-1:0] w_integ_sat;
    logic signed [PTERM_W-1:0]   w_pterm;
    logic signed [ITERM_W-1:0]   w_iterm;
    logic signed [RES_W-1:0]     w_res;

    // Saturate shares above one and pick the operands of the error ratio.
    always_comb begin
        w_f = (r_f_raw > FRAC_ONE) ? FRAC_ONE : r_f_raw;
        w_b = (i_cfg.hot_fraction > FRAC_ONE) ? FRAC_ONE : i_cfg.hot_fraction;
        w_a = FRAC_ONE - w_b;
        w_neg = (w_f < w_b);
        w_op_x    = w_neg ? w_a : w_b;
        w_op_y    = w_neg ? (w_b - w_f) : (w_f - w_b);
        w_divisor = w_neg ? w_b : w_a;
        w_num     = NUM_W'(w_op_x) * NUM_W'(w_op_y);
    end

    assign o_status.corner = (w_b == FRAC_ONE) && (w_f == FRAC_ONE);

    // One restoring step: the quotient never exceeds one, so FRAC_W steps suffice.
    assign w_trial = {r_rem, r_dq[FRAC_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign w_diff  = w_trial - {1'b0, r_div};

    always_comb begin
        w_err  = r_neg ? -$signed({1'b0, r_dq}) : $signed({1'b0, r_dq});
        w_isum = ACC_EXT_W'(r_integ) + ACC_EXT_W'(w_err);
        if (w_isum[ACC_EXT_W-1] != w_isum[ACC_EXT_W-2]) begin
            w_integ_sat = w_isum[ACC_EXT_W-1] ? ACC_MIN : ACC_MAX;
        end else begin
            w_integ_sat = ACC_WIDTH'(w_isum);
        end
    end

    // Shifted products stay well inside +/- 2^50, so no product limit applies.
    assign w_pterm = PTERM_W'(r_pprod >>> FRAC_BITS);
    assign w_iterm = ITERM_W'(r_iprod >>> FRAC_BITS);
    assign w_res   = RES_W'($signed({1'b0, r_b})) - RES_W'(r_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
        end else if (i_cmd.integ) begin
            r_integ <= w_integ_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_f_raw <= i_measured_fraction;
        end
        if (i_cmd.prep) begin
            r_f      <= w_f;
            r_b      <= w_b;
            r_neg    <= w_neg;
            r_bypass <= o_status.corner;
            r_div    <= w_divisor;
            r_rem    <= FRAC_W'(w_num[NUM_W-1:FRAC_W]);
            r_dq     <= w_num[FRAC_W-1:0];
        end
        if (i_cmd.div_step) begin
            r_rem <= w_ge ? w_diff[FRAC_W-1:0] : w_trial[FRAC_W-1:0];
            r_dq  <= {r_dq[FRAC_W-2:0], w_ge};
        end
        if (i_cmd.integ) begin
            r_err <= w_err;
        end
        if (i_cmd.mul0) begin
            r_pp_lo <= $signed({1'b0, r_integ[ACC_LO_W-1:0]}) * i_cfg.integ_gain;
            r_pprod <= r_err * i_cfg.prop_gain;
        end
        if (i_cmd.mul1) begin
            r_pp_hi <= $signed(r_integ[ACC_WIDTH-1:ACC_LO_W]) * i_cfg.integ_gain;
        end
        if (i_cmd.acc) begin
            r_iprod <= (IPROD_W'(r_pp_hi) <<< ACC_LO_W) + IPROD_W'(r_pp_lo);
        end
        if (i_cmd.sum) begin
            r_sum <= SUM_W'(w_pterm) + SUM_W'(w_iterm);
        end
        if (i_cmd.fin) begin
            r_bypass_out <= r_bypass;
            if (r_bypass) begin
                r_thr     <= r_f;
                r_clamped <= 1'b0;
            end else if (w_res > RES_ONE) begin
                r_thr     <= FRAC_ONE;
                r_clamped <= 1'b1;
            end else if (w_res < 0) begin
                r_thr     <= '0;
                r_clamped <= 1'b1;
            end else begin
                r_thr     <= w_res[FRAC_W-1:0];
                r_clamped <= 1'b0;
            end
        end
    end

    assign o_threshold = r_thr;
    assign o_clamped   = r_clamped;
    assign o_bypass    = r_bypass_out;

endmodule

/* src/asymmetric_pi_threshold_controller_core.sv */
// Top level of the asymmetric PI threshold controller with output clamp.
//
// Usage: write the target hot share, proportional gain and integral gain over
// the APB port (byte addresses 0, 4, 8) while the block is idle. Then stream
// measured hot shares (unsigned Q1.16) into the slave channel; each word gives
// one corrected threshold word on the master channel, with the clamped and
// bypass flags in tuser.
//
// Timing: after acceptance a normal word passes through a prepare step, the
// 17-step restoring divider that forms the error ratio, the integrate step,
// the split integral product (two multiply steps and an accumulate), the
// product sum and the final clamp step. The corner case where both shares are
// one skips the arithmetic and goes from the prepare step to the final step.
// One word is in work at a time; the next is taken once the block is idle again.
//
// Reset (synchronous, active low) loads the register reset values, clears the
// integrator and empties the output register. When the receiver stalls, the
// result holds in the output register; the next word is still accepted and
// worked on, and waits in its final step until the output register frees up.
module asymmetric_pi_threshold_controller_core import aptc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // APB configuration port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [DATA_W-1:0]      pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready,
    // input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [16:0] measured_fraction, rest zero
    // result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [16:0] threshold, rest zero
    output logic [OUT_TUSER_W-1:0] m_axis_tuser    // [0] clamped, [1] bypass
);

    t_cfg       w_cfg;
    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic [FRAC_W-1:0] w_threshold;
    logic              w_clamped, w_bypass;

    assign pready = 1'b1;

    // Hold the configuration registers and serve reads.
    aptc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (w_cfg)
    );

    // Sequence each word and own both handshakes.
    aptc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // Do the arithmetic and hold the result word.
    aptc_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg               (w_cfg),
        .i_cmd               (w_cmd),
        .i_measured_fraction (s_axis_tdata[FRAC_W-1:0]),
        .o_status            (w_status),
        .o_threshold         (w_threshold),
        .o_clamped           (w_clamped),
        .o_bypass            (w_bypass)
    );

    assign m_axis_tdata = OUT_TDATA_W'(w_threshold);
    assign m_axis_tuser = {w_bypass, w_clamped};

    // A word just taken keeps the input closed for the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted again right after a word was taken");

    // A bypass result is exactly one and never flagged as clamped.
    a_bypass_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |->
            (!m_axis_tuser[0] && (m_axis_tdata[FRAC_W-1:0] == FRAC_ONE)))
        else $error("bypass result is not a plain one");

    // Every threshold stays within zero through one.
    a_threshold_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[FRAC_W-1:0] <= FRAC_ONE))
        else $error("threshold above one");

    // A clamped result sits on one of the two limits.
    a_clamp_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |->
            ((m_axis_tdata[FRAC_W-1:0] == FRAC_ONE) || (m_axis_tdata[FRAC_W-1:0] == '0)))
        else $error("clamped result is not at a limit");

endmodule
